// ===== sv/exa_pkg.sv =====
`default_nettype none

package exa_pkg;

  // Fixed-point formats
  localparam int InFracBits   = 16;
  localparam int WorkFracBits = 24;
  localparam int CoefFracBits = 30;
  localparam int ProdShift    = InFracBits + CoefFracBits - WorkFracBits;
  localparam int CwShift      = CoefFracBits - WorkFracBits;

  // Datapath widths
  localparam int XW  = 24;       // argument
  localparam int LW  = 32;       // log2(e) constant
  localparam int PW  = XW + LW;  // argument product
  localparam int YW  = 34;       // y = x * log2(e), work format
  localparam int RW  = 10;       // integer part of y
  localparam int AW  = 26;       // Horner multiplicand (yf or f)
  localparam int CW  = 28;       // Horner accumulator
  localparam int HPW = AW + CW;  // Horner product
  localparam int VW  = 36;       // float bits before clamping
  localparam int FW  = 32;       // float word

  // Horner taps after the initial coefficient
  localparam int Taps = 5;

  localparam logic signed [LW-1:0] Log2eQ30 = 32'sd1549082005;

  localparam logic signed [VW-1:0] ShiftBias = 36'sd1065054451;
  localparam logic signed [VW-1:0] OneBits   = 36'sd1065353216;
  localparam logic signed [VW-1:0] Bits126   = 36'sd1056964608;
  localparam logic signed [VW-1:0] MinNormal = 36'sd8388608;
  localparam logic signed [VW-1:0] MaxBits   = 36'sd2139095040;
  localparam logic signed [VW-1:0] OneLsb    = 36'sd1;
  localparam logic [FW-1:0]        InfBits   = 32'h7F80_0000;

  typedef enum logic [1:0] {
    MethShift   = 2'd0,
    MethCubic   = 2'd1,
    MethQuintic = 2'd2,
    MethQuad    = 2'd3
  } method_e;

  typedef enum logic [1:0] {
    StNormal = 2'd0,
    StUnder  = 2'd1,
    StOver   = 2'd2
  } status_e;

  typedef struct packed {
    logic    valid;
    method_e method;
  } ctrl_t;

  typedef struct packed {
    logic signed [YW-1:0] y;
    logic signed [RW-1:0] r;
    logic signed [AW-1:0] a;
    logic signed [VW-1:0] v0;
    logic signed [CW-1:0] acc;
  } work_t;

  // Bring a Q30 constant to the work format, rounding half up
  function automatic logic signed [31:0] cw(input logic signed [31:0] c);
    logic signed [31:0] t;
    t = c + (32'sd1 <<< (CwShift - 1));
    return t >>> CwShift;
  endfunction

  localparam logic signed [31:0] CubC0 = cw(32'sd330261916);
  localparam logic signed [31:0] CubC1 = cw(-32'sd248477641);
  localparam logic signed [31:0] CubC2 = cw(-32'sd81784275);

  localparam logic signed [31:0] QuiC0 = cw(32'sd329480706);
  localparam logic signed [31:0] QuiC1 = cw(-32'sd257941248);
  localparam logic signed [31:0] QuiC2 = cw(-32'sd59821341);
  localparam logic signed [31:0] QuiC3 = cw(-32'sd9675987);
  localparam logic signed [31:0] QuiC4 = cw(-32'sd2042130);

  localparam logic signed [31:0] QuaC0 = cw(32'sd1074217644);
  localparam logic signed [31:0] QuaC1 = cw(32'sd755321545);
  localparam logic signed [31:0] QuaC2 = cw(32'sd256011121);

  // Coefficient added at each Horner tap; tap 0 seeds the accumulator.
  // Shorter polynomials are padded with leading zero terms.
  function automatic logic signed [CW-1:0] coef(input method_e m, input logic [2:0] tap);
    logic signed [31:0] c;
    c = 32'sd0;
    unique case (m)
      MethCubic: begin
        unique case (tap)
          3'd2:    c = CubC2;
          3'd3:    c = CubC1;
          3'd4:    c = CubC0;
          default: c = 32'sd0;
        endcase
      end
      MethQuintic: begin
        unique case (tap)
          3'd0:    c = QuiC4;
          3'd1:    c = QuiC3;
          3'd2:    c = QuiC2;
          3'd3:    c = QuiC1;
          3'd4:    c = QuiC0;
          default: c = 32'sd0;
        endcase
      end
      MethQuad: begin
        unique case (tap)
          3'd3:    c = QuaC2;
          3'd4:    c = QuaC1;
          3'd5:    c = QuaC0;
          default: c = 32'sd0;
        endcase
      end
      MethShift: c = 32'sd0;
    endcase
    return CW'(c);
  endfunction

endpackage

`default_nettype wire

// ===== sv/exa_prep.sv =====
`default_nettype none

module exa_prep import exa_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 in_valid_i,
  input  wire method_e              method_i,
  input  wire logic signed [XW-1:0] x_fixed_i,
  output ctrl_t                     ctrl_o,
  output work_t                     work_o
);

  localparam logic [WorkFracBits-1:0] HalfFrac = {1'b1, {(WorkFracBits-1){1'b0}}};
  localparam logic signed [AW-1:0]    OneW     = AW'(1) <<< WorkFracBits;

  // Stage A: argument times log2(e)
  logic signed [PW-1:0] prod_d, prod_q;
  ctrl_t                ctrl_a_d, ctrl_a_q;

  assign prod_d         = PW'(x_fixed_i) * PW'(Log2eQ30);
  assign ctrl_a_d.valid  = in_valid_i;
  assign ctrl_a_d.method = method_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
    end else if (en_i) begin
      ctrl_a_q <= ctrl_a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // Stage B: round to the work format, split integer and fraction
  ctrl_t ctrl_b_q;
  work_t work_d, work_q;

  always_comb begin
    logic signed [PW-1:0]       ysum;
    logic signed [YW-1:0]       y;
    logic [WorkFracBits-1:0]    yf;
    logic signed [RW-1:0]       fl;
    logic                       up;
    logic signed [AW-1:0]       yfa;
    logic signed [AW-1:0]       f;
    logic signed [VW-1:0]       yv;
    ysum = prod_q + (PW'(1) <<< (ProdShift - 1));
    y    = YW'(ysum >>> ProdShift);
    yf   = y[WorkFracBits-1:0];
    fl   = $signed(y[YW-1:WorkFracBits]);
    // round to nearest, ties to even
    up   = (yf > HalfFrac) || ((yf == HalfFrac) && fl[0]);
    yfa  = $signed({{(AW-WorkFracBits){1'b0}}, yf});
    f    = up ? (yfa - OneW) : yfa;
    yv   = VW'(y);

    work_d.y   = y;
    work_d.r   = fl + $signed({{(RW-1){1'b0}}, up});
    work_d.a   = (ctrl_a_q.method == MethQuad) ? f : yfa;
    work_d.v0  = ((yv + OneLsb) >>> 1) + ShiftBias;
    work_d.acc = coef(ctrl_a_q.method, 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_b_q <= '0;
    end else if (en_i) begin
      ctrl_b_q <= ctrl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign ctrl_o = ctrl_b_q;
  assign work_o = work_q;

endmodule

`default_nettype wire

// ===== sv/exa_horner.sv =====
`default_nettype none

module exa_horner import exa_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire ctrl_t ctrl_i,
  input  wire work_t work_i,
  output ctrl_t      ctrl_o,
  output work_t      work_o
);

  localparam logic signed [HPW-1:0] HalfP = HPW'(1) <<< (WorkFracBits - 1);

  ctrl_t ctrl_q [Taps];
  work_t work_d [Taps];
  work_t work_q [Taps];

  // One multiply, round and coefficient add per tap
  always_comb begin
    work_t                src;
    ctrl_t                csrc;
    logic signed [HPW-1:0] prod;
    for (int s = 0; s < Taps; s++) begin
      src  = (s == 0) ? work_i : work_q[s-1];
      csrc = (s == 0) ? ctrl_i : ctrl_q[s-1];
      prod = HPW'(src.a) * HPW'(src.acc);
      work_d[s]     = src;
      work_d[s].acc = coef(csrc.method, 3'(s + 1)) + CW'((prod + HalfP) >>> WorkFracBits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Taps; s++) begin
        ctrl_q[s] <= '0;
      end
    end else if (en_i) begin
      ctrl_q[0] <= ctrl_i;
      for (int s = 1; s < Taps; s++) begin
        ctrl_q[s] <= ctrl_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Taps; s++) begin
        work_q[s] <= work_d[s];
      end
    end
  end

  assign ctrl_o = ctrl_q[Taps-1];
  assign work_o = work_q[Taps-1];

endmodule

`default_nettype wire

// ===== sv/exa_pack.sv =====
`default_nettype none

module exa_pack import exa_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire ctrl_t ctrl_i,
  input  wire work_t work_i,
  output logic       out_valid_o,
  output logic [FW-1:0] float_bits_o,
  output status_e    status_o
);

  localparam logic signed [VW-1:0] OneV = VW'(1) <<< WorkFracBits;

  // Stage V: assemble the float bits for the selected method
  logic signed [VW-1:0] v_d, v_q;
  logic                 valid_v_q;

  always_comb begin
    logic signed [VW-1:0] yv, accv, rv, spl, t, pb, quad;
    yv   = VW'(work_i.y);
    accv = VW'(work_i.acc);
    rv   = VW'(work_i.r);
    spl  = ((yv - accv + OneLsb) >>> 1) + OneBits;
    if (accv >= OneV) begin
      t  = accv - OneV;
      pb = OneBits + ((t + OneLsb) >>> 1);
    end else begin
      t  = (accv <<< 1) - OneV;
      pb = Bits126 + ((t + OneLsb) >>> 1);
    end
    quad = (rv <<< 23) + pb;
    unique case (ctrl_i.method)
      MethShift:             v_d = work_i.v0;
      MethCubic, MethQuintic: v_d = spl;
      MethQuad:              v_d = quad;
    endcase
  end

  // Output stage: flush subnormals, clamp overflow to infinity
  logic [FW-1:0] float_d, float_q;
  status_e       status_d, status_q;
  logic          out_valid_q;

  always_comb begin
    priority if (v_q < MinNormal) begin
      float_d  = '0;
      status_d = StUnder;
    end else if (v_q >= MaxBits) begin
      float_d  = InfBits;
      status_d = StOver;
    end else begin
      float_d  = v_q[FW-1:0];
      status_d = StNormal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_v_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      valid_v_q   <= ctrl_i.valid;
      out_valid_q <= valid_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q      <= v_d;
      float_q  <= float_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign float_bits_o = float_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire

// ===== sv/exp_approx_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_ready_o  x_fixed_i (Q7.16, signed)
// out       output     out_valid_o / out_ready_i float_bits_o, status_o
// cfg       input      cfg_we_i (no wait)      cfg_wdata_i (method)
//
// Takes one word per cycle while in_ready_o is high. Its stages are the
// argument multiplier, its rounding stage, the five Horner multiply
// stages, the float assembly stage and the output register.
// Reset clears all valid bits and selects the quintic spline.
// A result not taken holds the whole pipeline; in_ready_o drops meanwhile.

module exp_approx_unit import exa_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic signed [XW-1:0] x_fixed_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [FW-1:0]             float_bits_o,
  output logic [1:0]                status_o
);

  method_e method_q;
  logic    en;
  ctrl_t   ctrl_prep, ctrl_horn;
  work_t   work_prep, work_horn;
  status_e status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= MethQuintic;
    end else if (cfg_we_i) begin
      method_q <= method_e'(cfg_wdata_i);
    end
  end

  // advance whenever the output word is empty or being taken
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  exa_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .method_i   (method_q),
    .x_fixed_i  (x_fixed_i),
    .ctrl_o     (ctrl_prep),
    .work_o     (work_prep)
  );

  exa_horner u_horner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctrl_i (ctrl_prep),
    .work_i (work_prep),
    .ctrl_o (ctrl_horn),
    .work_o (work_horn)
  );

  exa_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .ctrl_i       (ctrl_horn),
    .work_i       (work_horn),
    .out_valid_o  (out_valid_o),
    .float_bits_o (float_bits_o),
    .status_o     (status)
  );

  assign status_o = status;

endmodule

`default_nettype wire
